### hdl/assert_macros.svh
// Assertion macros shared by the echo ranging RTL.
// Depends on nothing; included by the modules that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset
`define UERH_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("uerh assertion failed");
// Next-cycle implication, disabled during reset
`define UERH_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("uerh assertion failed");
`else
`define UERH_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define UERH_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

### hdl/uerh_pkg.sv
// Shared types and constants of the ultrasonic echo ranging block.
// No dependencies.
package uerh_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_MAX_ECHO = 2'd0;
    localparam logic [1:0] REG_SCALE    = 2'd1;
    localparam logic [1:0] REG_NEAR     = 2'd2;
    localparam logic [1:0] REG_FAR      = 2'd3;

    // Register reset values
    localparam logic [7:0]  RST_MAX_ECHO = 8'd12;
    localparam logic [7:0]  RST_SCALE    = 8'd34;
    localparam logic [15:0] RST_NEAR     = 16'd50;
    localparam logic [15:0] RST_FAR      = 16'd100;

    // Channel codes
    localparam logic CH_UPPER = 1'b0;
    localparam logic CH_LOWER = 1'b1;

    typedef struct packed {
        logic [7:0]  max_echo;
        logic [7:0]  scale;
        logic [15:0] near_limit;
        logic [15:0] far_limit;
    } t_cfg;

    // Classified edge passed from front to back
    typedef struct packed {
        logic       channel;
        logic       measure;
        logic [7:0] width;
    } t_evt;

endpackage

### hdl/uerh_front.sv
// Front end: accepts echo edges, keeps rise stamps, measures echo width.
// Depends on uerh_pkg and assert_macros.svh.
`include "assert_macros.svh"
module uerh_front #(
    parameter int TIME_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_channel,
    input  logic                 i_echo_level,
    input  logic [TIME_BITS-1:0] i_time_ms,
    input  logic [7:0]           i_max_echo,
    input  logic                 i_full,
    output logic                 o_push,
    output uerh_pkg::t_evt       o_evt
);
    import uerh_pkg::*;

    logic [TIME_BITS-1:0] r_stamp [2];
    logic [TIME_BITS-1:0] n_stamp [2];
    logic [TIME_BITS-1:0] w_stamp;
    logic [TIME_BITS-1:0] w_width;
    logic                 w_short;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    // Width of the echo, wrapping modulo the timestamp range
    assign w_stamp = r_stamp[i_channel];
    assign w_width = i_time_ms - w_stamp;
    assign w_short = (w_width[TIME_BITS-1:8] == '0) && (w_width[7:0] < i_max_echo);

    always_comb begin
        o_evt.channel = i_channel;
        o_evt.width   = w_width[7:0];
        o_evt.measure = !i_echo_level && (w_stamp != '0) && w_short;
    end

    // Rise stores the stamp, fall clears it
    always_comb begin
        n_stamp = r_stamp;
        if (o_push) begin
            if (i_echo_level) begin
                n_stamp[i_channel] = i_time_ms;
            end else begin
                n_stamp[i_channel] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stamp[0] <= '0;
            r_stamp[1] <= '0;
        end else begin
            r_stamp <= n_stamp;
        end
    end

    `UERH_ASSERT_NXT(a_rise_upper, i_clk, i_rst_n,
        o_push && i_echo_level && (i_channel == CH_UPPER), r_stamp[0] == $past(i_time_ms))
    `UERH_ASSERT_NXT(a_fall_lower, i_clk, i_rst_n,
        o_push && !i_echo_level && (i_channel == CH_LOWER), r_stamp[1] == '0)

endmodule

### hdl/uerh_queue.sv
// Two-entry queue that decouples the front end from the back end.
// Depends on uerh_pkg and assert_macros.svh.
`include "assert_macros.svh"
module uerh_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  uerh_pkg::t_evt i_evt,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_avail,
    output uerh_pkg::t_evt o_evt
);
    import uerh_pkg::*;

    t_evt       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_avail = (r_count != 2'd0);
    assign o_evt   = r_mem[r_rd];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_evt;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    `UERH_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= 2'd2)
    `UERH_ASSERT_IMP(a_pop_nonempty, i_clk, i_rst_n, i_pop, r_count != 2'd0)

endmodule

### hdl/uerh_back.sv
// Back end: scales widths into distances, runs the hysteresis flags, and
// holds the result register. Depends on uerh_pkg and assert_macros.svh.
`include "assert_macros.svh"
module uerh_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_avail,
    input  uerh_pkg::t_evt i_evt,
    output logic           o_pop,
    input  uerh_pkg::t_cfg i_cfg,
    output logic           o_valid,
    input  logic           i_ready,
    output logic           o_out_channel,
    output logic [15:0]    o_distance,
    output logic           o_measured,
    output logic           o_upper_close,
    output logic           o_lower_open
);
    import uerh_pkg::*;

    logic [15:0] r_range [2];
    logic        r_close;
    logic        r_open;
    logic        r_valid;
    logic [15:0] w_prev;
    logic [15:0] w_cur;
    logic [15:0] w_prod;
    logic        n_close;
    logic        n_open;

    // Output register frees up when empty or being taken
    assign o_pop   = i_avail && (!r_valid || i_ready);
    assign o_valid = r_valid;

    // Width below 256 and scale below 256 always fit 16 bits
    assign w_prod = {8'd0, i_evt.width} * {8'd0, i_cfg.scale};
    assign w_prev = r_range[i_evt.channel];
    assign w_cur  = i_evt.measure ? w_prod : w_prev;

    // Hysteresis on the channel of this transaction
    always_comb begin
        n_close = r_close;
        n_open  = r_open;
        if (i_evt.channel == CH_UPPER) begin
            if ((w_cur < i_cfg.near_limit) && (w_prev > i_cfg.far_limit)) begin
                n_close = 1'b1;
            end
            if (w_cur > i_cfg.far_limit) begin
                n_close = 1'b0;
            end
        end else begin
            if ((w_prev < i_cfg.near_limit) && (w_cur > i_cfg.far_limit)) begin
                n_open = 1'b1;
            end
            if (w_cur < i_cfg.near_limit) begin
                n_open = 1'b0;
            end
        end
    end

    // Channel state and valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range[0] <= '0;
            r_range[1] <= '0;
            r_close    <= 1'b1;
            r_open     <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            if (o_pop) begin
                r_range[i_evt.channel] <= w_cur;
                r_close                <= n_close;
                r_open                 <= n_open;
                r_valid                <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            o_out_channel <= i_evt.channel;
            o_distance    <= w_cur;
            o_measured    <= i_evt.measure;
            o_upper_close <= n_close;
            o_lower_open  <= n_open;
        end
    end

    `UERH_ASSERT_NXT(a_pop_fills, i_clk, i_rst_n, o_pop, r_valid)
    `UERH_ASSERT_NXT(a_range_kept, i_clk, i_rst_n,
        o_pop && !i_evt.measure && (i_evt.channel == CH_UPPER), r_range[0] == $past(r_range[0]))

endmodule

### hdl/ultrasonic_echo_range_hysteresis_top.sv
// Two-channel ultrasonic echo ranging with hysteresis flags. Accepts one echo
// edge transaction per clock while the queue has room and returns one result
// transaction for each, in order; an accepted edge passes through the queue into
// the output register, from which its result is offered. Sustained throughput is
// one transaction per cycle while the output side is not stalled, set by the
// rise-stamp update in the front end and the distance and flag update in the back
// end; a two-entry queue between them and the output register let either side
// stall alone. Configuration writes are taken at any time but should be made only
// while the block is idle.
// Depends on uerh_pkg, uerh_front, uerh_queue and uerh_back.
module ultrasonic_echo_range_hysteresis_top #(
    parameter int TIME_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [1:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_wdata,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_channel,
    input  logic                 i_echo_level,
    input  logic [TIME_BITS-1:0] i_time_ms,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_out_channel,
    output logic [15:0]          o_distance,
    output logic                 o_measured,
    output logic                 o_upper_close,
    output logic                 o_lower_open
);
    import uerh_pkg::*;

    t_cfg r_cfg;
    t_evt w_front_evt;
    t_evt w_queue_evt;
    logic w_push;
    logic w_full;
    logic w_pop;
    logic w_avail;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_echo   <= RST_MAX_ECHO;
            r_cfg.scale      <= RST_SCALE;
            r_cfg.near_limit <= RST_NEAR;
            r_cfg.far_limit  <= RST_FAR;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_MAX_ECHO: r_cfg.max_echo   <= i_cfg_wdata[7:0];
                REG_SCALE:    r_cfg.scale      <= i_cfg_wdata[7:0];
                REG_NEAR:     r_cfg.near_limit <= i_cfg_wdata;
                REG_FAR:      r_cfg.far_limit  <= i_cfg_wdata;
                default:      r_cfg            <= r_cfg;
            endcase
        end
    end

    uerh_front #(
        .TIME_BITS (TIME_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_channel    (i_channel),
        .i_echo_level (i_echo_level),
        .i_time_ms    (i_time_ms),
        .i_max_echo   (r_cfg.max_echo),
        .i_full       (w_full),
        .o_push       (w_push),
        .o_evt        (w_front_evt)
    );

    uerh_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_evt   (w_front_evt),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_avail (w_avail),
        .o_evt   (w_queue_evt)
    );

    uerh_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_avail       (w_avail),
        .i_evt         (w_queue_evt),
        .o_pop         (w_pop),
        .i_cfg         (r_cfg),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_channel (o_out_channel),
        .o_distance    (o_distance),
        .o_measured    (o_measured),
        .o_upper_close (o_upper_close),
        .o_lower_open  (o_lower_open)
    );

endmodule
